>>> sv/lchm_pkg.sv
// shared types, constants and key folding for the lru cache cost block
package lchm_pkg;

  localparam int unsigned DefMaxEntries = 32;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned CapW          = 6;
  localparam int unsigned CostW         = 3;
  localparam int unsigned TotalW        = 24;

  localparam logic [CostW-1:0]  HitCost   = 3'd1;
  localparam logic [CostW-1:0]  MissCost  = 3'd5;
  localparam logic [TotalW-1:0] TotalMax  = 24'hFFFFFF;

  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5A;
  localparam logic [7:0] CaseOffset  = 8'd32;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [CostW-1:0]  access_cost;
    logic [TotalW-1:0] total_cost;
    logic              last_out;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } state_e;

  // fold upper-case ascii bytes to lower case
  function automatic logic [KeyW-1:0] fold_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic [7:0]      c;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      c = k[8*b +: 8];
      if (c >= AsciiUpperA && c <= AsciiUpperZ) begin
        c = c + CaseOffset;
      end
      r[8*b +: 8] = c;
    end
    return r;
  endfunction

endpackage

>>> sv/lchm_ram.sv
// simple dual port synchronous ram, one write and one registered read
module lchm_ram
  import lchm_pkg::*;
#(
  parameter int unsigned Width = KeyW,
  parameter int unsigned Depth = DefMaxEntries,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/lru_cache_hit_miss_cost.sv
// lru cache hit/miss cost block: fully associative key store with a running cost total
//
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one access: a packed
// 8-byte ascii key, folded to lower case internally, and a last flag.
// Output channel (out_valid_o/out_ready_i, out_data_o) returns one result per
// access: hit, access cost (1 on hit, 5 on miss), saturating running total and
// an echo of last. After a result marked last the store and the total clear.
// cfg_we_i/cfg_wdata_i write the capacity; zero makes every access a miss.
// Keys and ranks live in two rams with a registered read. Valid entries
// are always the lowest entry_count slots, so a fill count replaces valid bits.
// One pipelined pass over the rams finds the match and the oldest entry, a
// second pass rewrites the ranks, and the next access is taken once the result
// is loaded. With capacity zero both passes are skipped.
// One access is in flight at a time; a finished result sits in an output
// register, so a new access is taken while it waits. A stalled receiver holds
// the next access in its final state until the register frees.
// Reset empties the store, zeroes the total and the capacity; no clearing pass.
module lru_cache_hit_miss_cost
  import lchm_pkg::*;
#(
  parameter int unsigned MaxEntries = DefMaxEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  state_e state_q, state_d;

  logic [CapW-1:0]   cap_q;
  logic [CntW-1:0]   cap_eff;
  logic [KeyW-1:0]   key_q, key_d;
  logic              last_q, last_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]   chk_idx_q, chk_idx_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   found_idx_q, found_idx_d;
  logic [IdxW-1:0]   found_rank_q, found_rank_d;
  logic [IdxW-1:0]   old_idx_q, old_idx_d;
  out_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic              in_fire, out_free, issue, fill;
  logic [IdxW-1:0]   target;
  logic [KeyW-1:0]   key_rd;
  logic [IdxW-1:0]   rank_rd, new_rank;
  logic              key_we, rank_we;
  logic [IdxW-1:0]   rank_waddr, rank_wdata;
  logic [CostW-1:0]  cost;
  logic [TotalW:0]   sum;

  assign cap_eff  = (int'(cap_q) > MaxEntries) ? CntW'(MaxEntries) : CntW'(cap_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;
  assign issue    = (idx_q < count_q);
  assign fill     = (count_q < cap_eff);
  assign target   = found_q ? found_idx_q : (fill ? count_q[IdxW-1:0] : old_idx_q);

  assign cost = found_q ? HitCost : MissCost;
  assign sum  = {1'b0, total_q} + {{(TotalW + 1 - CostW){1'b0}}, cost};

  // rank rewrite for one entry during the update pass
  always_comb begin
    if (chk_idx_q == target) begin
      new_rank = '0;
    end else if (found_q) begin
      new_rank = (rank_rd < found_rank_q) ? rank_rd + IdxW'(1) : rank_rd;
    end else begin
      new_rank = rank_rd + IdxW'(1);
    end
  end

  assign key_we     = (state_q == ST_DONE) && out_free && !found_q && (cap_eff != '0);
  assign rank_we    = ((state_q == ST_UPD) && chk_vld_q) || key_we;
  assign rank_waddr = (state_q == ST_UPD) ? chk_idx_q : target;
  assign rank_wdata = (state_q == ST_UPD) ? new_rank : '0;

  lchm_ram #(
    .Width (KeyW),
    .Depth (MaxEntries)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (target),
    .wdata_i (key_q),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (key_rd)
  );

  lchm_ram #(
    .Width (IdxW),
    .Depth (MaxEntries)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rank_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (cap_eff == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !chk_vld_q) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!issue && !chk_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    key_d        = key_q;
    last_d       = last_q;
    count_d      = count_q;
    total_d      = total_q;
    idx_d        = idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_rank_d = found_rank_q;
    old_idx_d    = old_idx_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d   = fold_key(in_data_i.key);
          last_d  = in_data_i.last;
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
        chk_vld_d = issue;
        chk_idx_d = idx_q[IdxW-1:0];
        if (chk_vld_q) begin
          if (!found_q && key_rd == key_q) begin
            found_d      = 1'b1;
            found_idx_d  = chk_idx_q;
            found_rank_d = rank_rd;
          end
          if (CntW'(rank_rd) == count_q - CntW'(1)) begin
            old_idx_d = chk_idx_q;
          end
        end
        if (!issue && !chk_vld_q) begin
          idx_d = '0;
        end
      end
      ST_UPD: begin
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
        chk_vld_d = issue;
        chk_idx_d = idx_q[IdxW-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          out_d.hit         = found_q;
          out_d.access_cost = cost;
          out_d.total_cost  = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
          out_d.last_out    = last_q;
          total_d           = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
          if (!found_q && cap_eff != '0 && fill) begin
            count_d = count_q + CntW'(1);
          end
          if (last_q) begin
            count_d = '0;
            total_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= '0;
      count_q   <= '0;
      total_q   <= '0;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      total_q   <= total_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    last_q       <= last_d;
    chk_idx_q    <= chk_idx_d;
    found_idx_q  <= found_idx_d;
    found_rank_q <= found_rank_d;
    old_idx_q    <= old_idx_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // fill count never runs past the store depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= MaxEntries)
    else $error("entry count beyond store depth");

  // leaving the final state always loads a result
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_vld_q)
    else $error("finished transaction produced no result");

  // a last transaction empties the store and the total
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free && last_q) |=> (count_q == '0 && total_q == '0))
    else $error("store or total not cleared after last");

  // a match can only come from a stored entry
  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && found_q) |-> (CntW'(found_idx_q) < count_q))
    else $error("match index outside filled entries");

endmodule
